FILE: sv/rrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types, codes and defaults for the record ring queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int SLOT_BYTES_DEF = 64;

    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 5;
    localparam int ST_W   = 2;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd16;
    localparam logic [CNT_W-1:0] HELD_MAX     = 5'd31;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAIR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_UNINIT = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SINGLE,
        PH_FIRST,
        PH_SECOND
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_LEN,
        S_POP_READ,
        S_POP_EMIT
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [BYTE_W-1:0] data_byte;
        logic              has_byte;
        logic              byte_last;
        logic              pair_second;
        logic [LEN_W-1:0]  dest_len;
    } in_item_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] out_byte;
        logic              out_byte_valid;
        logic              out_last;
        logic [CNT_W-1:0]  entry_count;
        logic [LEN_W-1:0]  copy_size;
    } out_item_t;

    typedef struct packed {
        logic push_step;
        logic pop_reject;
        logic pop_start;
        logic cs_load;
        logic pop_emit_none;
        logic pop_emit_byte;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic req_push;
        logic req_pop;
        logic pop_reject;
        logic cs_zero;
        logic rd_last;
    } sts_t;

endpackage

FILE: sv/record_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_ring_queue
// Ring of fixed-size record slots with byte-wise push, pair push and pop.
// ----------------------------------------------------------------------------
// Push beats (single or pair) are taken in the idle state, so records stream
// in at one byte per cycle while the result register drains; the closing beat
// of a single record, or of a pair's second record, gives one result. A pop
// walks a length-fetch state, then a read and an emit state per delivered
// byte, set by the byte memory's registered read port; empty pops skip both.
// No new request is taken until the pop's last byte sits in the result
// register. Slot lengths read as zero until written, so no clearing pass
// follows reset. Write active_slots only while no record is open or popping.
module record_ring_queue #(
    parameter int SLOTS      = rrq_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = rrq_pkg::SLOT_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wen,
    input  logic [rrq_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rrq_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rrq_pkg::out_item_t        out_item
);
    import rrq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrq_dp #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_item),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

FILE: sv/rrq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rrq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ctrl
// Sequencer: takes request beats and walks a pop through length fetch and
// byte streaming.
// ----------------------------------------------------------------------------
module rrq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rrq_pkg::sts_t sts,
    output rrq_pkg::cmd_t cmd
);
    import rrq_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.req_pop && !sts.pop_reject)
                begin
                    state_next = S_POP_LEN;
                end
            end
            S_POP_LEN:
            begin
                if (!sts.cs_zero)
                begin
                    state_next = S_POP_READ;
                end
                else if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP_READ:
            begin
                state_next = S_POP_EMIT;
            end
            S_POP_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.rd_last ? S_IDLE : S_POP_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.push_step  = sts.req_push;
                    cmd.pop_reject = sts.req_pop && sts.pop_reject;
                    cmd.pop_start  = sts.req_pop && !sts.pop_reject;
                end
            end
            S_POP_LEN:
            begin
                cmd.cs_load       = 1'b1;
                cmd.pop_emit_none = sts.cs_zero && sts.out_free;
            end
            S_POP_READ:
            begin
                cmd = '0;
            end
            S_POP_EMIT:
            begin
                cmd.pop_emit_byte = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: sv/rrq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_dp
// Datapath: ring pointers, open-record tracking, slot memories and the
// result register.
// ----------------------------------------------------------------------------
module rrq_dp #(
    parameter int SLOTS      = 16,
    parameter int SLOT_BYTES = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [rrq_pkg::CNT_W-1:0]   cfg_wdata,
    input  rrq_pkg::in_item_t           in_item,
    input  logic                        out_ready,
    input  rrq_pkg::cmd_t               cmd,
    output rrq_pkg::sts_t               sts,
    output logic                        out_valid,
    output rrq_pkg::out_item_t          out_item
);
    import rrq_pkg::*;

    localparam int IW    = $clog2(SLOTS);
    localparam int OW    = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int XW    = (IW + 1 > 6) ? IW + 1 : 6;
    localparam int BDEPTH = SLOTS * (1 << OW);

    function automatic logic [IW-1:0] next_index(input logic [IW-1:0] i,
                                                 input logic [CNT_W-1:0] sz);
        logic [XW-1:0] n;
        n = XW'(i) + XW'(1);
        if (n >= XW'(sz) || n >= XW'(SLOTS))
            return '0;
        return n[IW-1:0];
    endfunction

    // control state
    logic [CNT_W-1:0] active_reg, active_next;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [LEN_W-1:0] woff_reg, woff_next;
    phase_t           phase_reg, phase_next;
    logic             rej_reg, rej_next;
    logic [SLOTS-1:0] len_valid_reg, len_valid_next;
    logic [OW-1:0]    rdoff_reg, rdoff_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [LEN_W-1:0] dest_reg, dest_next;
    logic [LEN_W-1:0] cs_reg, cs_next;
    out_item_t        out_reg, out_next;

    logic [CNT_W-1:0] size;
    phase_t           phase_eff;
    logic             rej_eff;
    logic [LEN_W-1:0] woff_eff;
    logic [LEN_W-1:0] woff_inc;
    logic [IW-1:0]    slot;
    logic             byte_we;
    logic             len_we;
    logic [CNT_W:0]   held_sum;
    logic [CNT_W-1:0] held_sat;
    logic [LEN_W-1:0] len_rdata;
    logic [LEN_W-1:0] stored;
    logic [LEN_W-1:0] cs_now;
    logic [BYTE_W-1:0] byte_rdata;
    logic             pop_finish;
    logic             out_load;

    assign size = (XW'(active_reg) < XW'(SLOTS)) ? active_reg : CNT_W'(SLOTS);

    // open-record view for the beat on the input
    always_comb
    begin
        phase_eff = phase_reg;
        rej_eff   = rej_reg;
        woff_eff  = woff_reg;
        if (phase_reg == PH_IDLE)
        begin
            woff_eff = '0;
            if (in_item.req_type == REQ_PUSH)
            begin
                phase_eff = PH_SINGLE;
                rej_eff   = (size == '0) || (held_reg >= size);
            end
            else
            begin
                phase_eff = PH_FIRST;
                rej_eff   = (size < CNT_W'(2)) || (held_reg > size - CNT_W'(2));
            end
        end
        slot     = (phase_eff == PH_SECOND) ? next_index(tail_reg, size) : tail_reg;
        byte_we  = cmd.push_step && !rej_eff && in_item.has_byte
                   && (woff_eff < LEN_W'(SLOT_BYTES));
        woff_inc = woff_eff + (byte_we ? LEN_W'(1) : LEN_W'(0));
        len_we   = cmd.push_step && in_item.byte_last && !rej_eff;
        held_sum = {1'b0, held_reg} + ((phase_eff == PH_SECOND) ? 6'd2 : 6'd1);
        held_sat = (held_sum > {1'b0, HELD_MAX}) ? HELD_MAX : held_sum[CNT_W-1:0];
    end

    // pop view
    assign stored     = len_valid_reg[head_reg] ? len_rdata : '0;
    assign cs_now     = (stored < dest_reg) ? stored : dest_reg;
    assign pop_finish = cmd.pop_emit_none || (cmd.pop_emit_byte && sts.rd_last);

    always_comb
    begin
        sts.out_free   = !out_valid_reg || out_ready;
        sts.req_push   = (in_item.req_type == REQ_PUSH) || (in_item.req_type == REQ_PAIR);
        sts.req_pop    = (in_item.req_type == REQ_POP);
        sts.pop_reject = (held_reg == '0) || (size == '0);
        sts.cs_zero    = (cs_now == '0);
        sts.rd_last    = (LEN_W'(rdoff_reg) + LEN_W'(1)) == cs_reg;
    end

    always_comb
    begin
        active_next    = cfg_wen ? cfg_wdata : active_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        woff_next      = woff_reg;
        phase_next     = phase_reg;
        rej_next       = rej_reg;
        len_valid_next = len_valid_reg;
        rdoff_next     = rdoff_reg;
        dest_next      = dest_reg;
        cs_next        = cmd.cs_load ? cs_now : cs_reg;
        out_next       = out_reg;
        out_load       = 1'b0;

        if (len_we)
        begin
            len_valid_next[slot] = 1'b1;
        end

        if (cmd.push_step)
        begin
            if (!in_item.byte_last)
            begin
                // hold the record open
                woff_next  = woff_inc;
                phase_next = phase_eff;
                rej_next   = rej_eff;
            end
            else if (phase_eff == PH_FIRST)
            begin
                woff_next  = '0;
                phase_next = PH_SECOND;
                rej_next   = rej_eff;
            end
            else
            begin
                woff_next   = '0;
                phase_next  = PH_IDLE;
                rej_next    = 1'b0;
                out_load    = 1'b1;
                out_next    = '0;
                out_next.out_last = 1'b1;
                if (rej_eff)
                begin
                    out_next.status      = (size == '0) ? ST_UNINIT : ST_FULL;
                    out_next.entry_count = held_reg;
                end
                else
                begin
                    out_next.status      = ST_OK;
                    out_next.entry_count = held_sat;
                    held_next            = held_sat;
                    tail_next = (phase_eff == PH_SECOND)
                                ? next_index(next_index(tail_reg, size), size)
                                : next_index(tail_reg, size);
                end
            end
        end

        if (cmd.pop_reject)
        begin
            out_load          = 1'b1;
            out_next          = '0;
            out_next.status   = (held_reg == '0) ? ST_EMPTY : ST_UNINIT;
            out_next.out_last = 1'b1;
        end

        if (cmd.pop_start)
        begin
            dest_next  = in_item.dest_len;
            rdoff_next = '0;
        end

        if (cmd.pop_emit_none)
        begin
            out_load          = 1'b1;
            out_next          = '0;
            out_next.status   = ST_OK;
            out_next.out_last = 1'b1;
        end

        if (cmd.pop_emit_byte)
        begin
            out_load                = 1'b1;
            out_next                = '0;
            out_next.status         = ST_OK;
            out_next.out_byte       = byte_rdata;
            out_next.out_byte_valid = 1'b1;
            out_next.out_last       = sts.rd_last;
            out_next.copy_size      = cs_reg;
            rdoff_next              = rdoff_reg + OW'(1);
        end

        if (pop_finish)
        begin
            // free the head slot
            len_valid_next[head_reg] = 1'b0;
            held_next                = held_reg - CNT_W'(1);
            head_next                = next_index(head_reg, size);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= ACTIVE_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            woff_reg      <= '0;
            phase_reg     <= PH_IDLE;
            rej_reg       <= 1'b0;
            len_valid_reg <= '0;
            rdoff_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            woff_reg      <= woff_next;
            phase_reg     <= phase_next;
            rej_reg       <= rej_next;
            len_valid_reg <= len_valid_next;
            rdoff_reg     <= rdoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        cs_reg   <= cs_next;
        out_reg  <= out_next;
    end

    rrq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BDEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (byte_we),
        .waddr ({slot, woff_eff[OW-1:0]}),
        .wdata (in_item.data_byte),
        .raddr ({head_reg, rdoff_reg}),
        .rdata (byte_rdata)
    );

    rrq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (slot),
        .wdata (woff_inc),
        .raddr (head_reg),
        .rdata (len_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

FILE: sv/rrq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the result channel of the record ring queue.
// ----------------------------------------------------------------------------
module rrq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rrq_pkg::out_item_t out_item
);
    import rrq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result beat changed while stalled");

    // a result without a byte always closes its request
    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.out_byte_valid |-> out_item.out_last)
        else $error("byteless result not marked last");

    // popped bytes are ok results with a non-zero copy size and no count
    a_byte_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_byte_valid |->
            out_item.status == ST_OK && out_item.entry_count == '0
            && out_item.copy_size != '0)
        else $error("popped byte with inconsistent fields");

    // no request taken while a pop is still streaming
    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.out_byte_valid && !out_item.out_last |-> !in_ready)
        else $error("request accepted in the middle of a pop");

endmodule

bind record_ring_queue rrq_checker u_rrq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
